[design/sbeq_pkg.sv]
`default_nettype none
package sbeq_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_IDX_W = 5;
   localparam int COEF_W     = 32;
   localparam int SIG_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WIDTH_W    = 16;
   localparam int TAPS       = 5;
   localparam int WIDTH_MAX  = 32768;
   localparam int LIM_THRESH = 32000;
   localparam int LIM_KNEE   = 767;

   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_COEF  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DSP_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITER_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_GAIN      = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_MAC, ST_WB, ST_MS1, ST_MS2,
      ST_LSET, ST_LDIV, ST_LFIN, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_MAC, OP_WB, OP_MS1, OP_MS2,
      OP_LSET, OP_LDIV, OP_LFIN, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   bypass;
   } dp_cmd_type;

   typedef struct packed {
      logic action;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

[design/sbeq_if.sv]
`default_nettype none
interface sbeq_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] left_in;
   logic [15:0] right_in;
   logic        frame_last;
   logic [4:0]  coef_index;
   logic [31:0] coef_value;
   modport source (output valid, action, left_in, right_in, frame_last, coef_index,
                   coef_value, input ready);
   modport sink (input valid, action, left_in, right_in, frame_last, coef_index,
                 coef_value, output ready);
endinterface

interface sbeq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] left_out;
   logic [15:0] right_out;
   logic        last_out;
   modport source (output valid, left_out, right_out, last_out, input ready);
   modport sink (input valid, left_out, right_out, last_out, output ready);
endinterface

interface sbeq_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/sbeq_ctrl.sv]
`default_nettype none
module sbeq_ctrl #(
   parameter int NUM_SECTIONS  = 4,
   parameter int SIG_FRAC_BITS = 8,
   localparam int SECW = $clog2(NUM_SECTIONS + 1),
   localparam int QW   = 10 + SIG_FRAC_BITS,
   localparam int CNTW = $clog2(QW)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   dsp_enable,
   input  wire logic                   lowpass_enable,
   input  wire logic                   limiter_enable,
   input  wire sbeq_pkg::dp_status_type status,
   output sbeq_pkg::dp_cmd_type        cmd,
   output logic [SECW-1:0]             sec,
   output logic                        ch,
   output logic [CNTW-1:0]             cnt
);
   import sbeq_pkg::*;

   state_type       state_ff, state_in;
   logic [SECW-1:0] sec_ff, sec_in;
   logic            ch_ff, ch_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [SECW-1:0] sec_start;

   assign sec_start = lowpass_enable ? '0 : SECW'(1);
   assign sec = sec_ff;
   assign ch  = ch_ff;
   assign cnt = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sec_ff   <= '0;
         ch_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sec_in     = sec_ff;
      ch_in      = ch_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.bypass = !dsp_enable;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            sec_in = sec_start;
            ch_in  = 1'b0;
            cnt_in = '0;
            if (status.action == ACT_COEF) begin
               state_in = ST_IDLE;
            end else if (!dsp_enable) begin
               state_in = ST_EMIT;
            end else if (32'(sec_start) >= NUM_SECTIONS) begin
               state_in = ST_MS1;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.op = OP_MAC;
            if (cnt_ff == CNTW'(TAPS)) begin
               cnt_in   = '0;
               state_in = ST_WB;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         ST_WB: begin
            cmd.op = OP_WB;
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = ST_MAC;
            end else begin
               ch_in  = 1'b0;
               sec_in = sec_ff + SECW'(1);
               if (sec_ff + SECW'(1) == SECW'(NUM_SECTIONS)) begin
                  state_in = ST_MS1;
               end else begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MS1: begin
            cmd.op   = OP_MS1;
            state_in = ST_MS2;
         end
         ST_MS2: begin
            cmd.op   = OP_MS2;
            ch_in    = 1'b0;
            state_in = limiter_enable ? ST_LSET : ST_EMIT;
         end
         ST_LSET: begin
            cmd.op   = OP_LSET;
            cnt_in   = CNTW'(QW - 1);
            state_in = ST_LDIV;
         end
         ST_LDIV: begin
            cmd.op = OP_LDIV;
            if (cnt_ff == '0) begin
               state_in = ST_LFIN;
            end else begin
               cnt_in = cnt_ff - CNTW'(1);
            end
         end
         ST_LFIN: begin
            cmd.op = OP_LFIN;
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = ST_LSET;
            end else begin
               ch_in    = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[design/sbeq_dp.sv]
`default_nettype none
module sbeq_dp #(
   parameter int NUM_SECTIONS   = 4,
   parameter int COEF_FRAC_BITS = 28,
   parameter int SIG_FRAC_BITS  = 8,
   localparam int SECW = $clog2(NUM_SECTIONS + 1),
   localparam int QW   = 10 + SIG_FRAC_BITS,
   localparam int CNTW = $clog2(QW)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sbeq_pkg::dp_cmd_type    cmd,
   input  wire logic [SECW-1:0]         sec,
   input  wire logic                    ch,
   input  wire logic [CNTW-1:0]         cnt,
   output sbeq_pkg::dp_status_type      status,
   input  wire logic [sbeq_pkg::WIDTH_W-1:0] side_gain,
   input  wire logic                    req_action,
   input  wire logic [15:0]             req_left_in,
   input  wire logic [15:0]             req_right_in,
   input  wire logic                    req_frame_last,
   input  wire logic [4:0]              req_coef_index,
   input  wire logic [31:0]             req_coef_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [15:0]                  rsp_left_out,
   output logic [15:0]                  rsp_right_out,
   output logic                         rsp_last_out
);
   import sbeq_pkg::*;

   localparam int COEF_COUNT  = NUM_SECTIONS * TAPS;
   localparam int DELAY_COUNT = NUM_SECTIONS * 8;
   localparam int CIW = $clog2(COEF_COUNT);
   localparam int DIW = $clog2(DELAY_COUNT);
   localparam int AW  = 2 * COEF_W + 3;
   localparam int MW  = 52;
   localparam int LW  = 38;
   localparam int NW  = LW + QW + 1;
   localparam logic signed [LW-1:0] TH = LW'(LIM_THRESH * (1 << SIG_FRAC_BITS));
   localparam logic [QW-1:0] KN = QW'(LIM_KNEE * (1 << SIG_FRAC_BITS));

   function automatic logic [15:0] to_sample(input logic signed [LW-1:0] v);
      logic [LW-1:0] mag;
      logic [LW-1:0] s;
      logic [15:0]   res;
      mag = v[LW-1] ? LW'(-v) : LW'(v);
      s   = mag >> SIG_FRAC_BITS;
      if (v[LW-1]) begin
         res = (s > LW'(32768)) ? 16'h8000 : 16'(-s);
      end else begin
         res = (s > LW'(32767)) ? 16'h7fff : s[15:0];
      end
      return res;
   endfunction

   // frame capture and working samples
   logic                    action_ff, last_ff;
   logic [15:0]             in_l_ff, in_r_ff;
   logic signed [SIG_W-1:0] l_ff, r_ff;
   logic [COEF_W-1:0]       coef_ff [COEF_COUNT];
   logic [SIG_W-1:0]        delay_ff [DELAY_COUNT];
   logic signed [2*COEF_W-1:0] prod_ff;
   logic                    neg_ff;
   logic signed [AW-1:0]    acc_ff;
   logic signed [MW-1:0]    ms_sum_ff, ms_dif_ff;
   logic signed [LW-1:0]    lo_ff, ro_ff;
   logic                    lim_pos_ff, lim_neg_ff;
   logic [NW-1:0]           num_ff, den_ff;
   logic [QW-1:0]           q_ff;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_l_ff, rsp_r_ff;
   logic                    rsp_last_ff;

   // biquad tap selection
   logic [2:0]              k_eff;
   logic [CIW-1:0]          cidx;
   logic [DIW-1:0]          dbase;
   logic signed [SIG_W-1:0] x_cur, opnd;
   logic signed [COEF_W-1:0] coef_rd;
   logic signed [2*COEF_W-1:0] prod_mul;
   logic signed [AW-1:0]    y_full;
   logic [SIG_W-1:0]        y_sat;

   assign k_eff   = (cnt < CNTW'(TAPS)) ? cnt[2:0] : 3'd0;
   assign cidx    = CIW'(32'(sec) * TAPS + 32'(k_eff));
   assign dbase   = DIW'({sec, ch, 2'b00});
   assign x_cur   = ch ? r_ff : l_ff;
   assign opnd    = (k_eff == 3'd0) ? x_cur
                    : $signed(delay_ff[dbase + DIW'(k_eff - 3'd1)]);
   assign coef_rd = $signed(coef_ff[cidx]);
   assign prod_mul = coef_rd * opnd;
   assign y_full  = acc_ff >>> COEF_FRAC_BITS;

   always_comb begin
      if (&y_full[AW-1:SIG_W-1] || ~|y_full[AW-1:SIG_W-1]) begin
         y_sat = y_full[SIG_W-1:0];
      end else begin
         y_sat = y_full[AW-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
      end
   end

   // mid/side
   logic signed [SIG_W:0]   sum33, dif33;
   logic [16:0]             w17;
   logic signed [MW-1:0]    ms_l, ms_r;

   assign sum33 = {l_ff[SIG_W-1], l_ff} + {r_ff[SIG_W-1], r_ff};
   assign dif33 = {l_ff[SIG_W-1], l_ff} - {r_ff[SIG_W-1], r_ff};
   assign w17   = (32'(side_gain) > WIDTH_MAX) ? 17'(WIDTH_MAX) : {1'b0, side_gain};
   assign ms_l  = ms_sum_ff + ms_dif_ff + MW'(16384);
   assign ms_r  = ms_sum_ff - ms_dif_ff + MW'(16384);

   // limiter
   logic signed [LW-1:0] lv, ld, lres;
   logic                 lpos, lneg;
   logic [NW-1:0]        trial;

   assign lv    = ch ? ro_ff : lo_ff;
   assign lpos  = lv > TH;
   assign lneg  = lv < -TH;
   assign ld    = lpos ? (lv - TH) : (lneg ? -(lv + TH) : '0);
   assign trial = den_ff << cnt;
   assign lres  = lim_pos_ff ? (TH + LW'(q_ff)) : (-TH - LW'(q_ff));

   assign status.action   = action_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) begin
            coef_ff[i] <= (i % TAPS == 0) ? COEF_W'(1) << COEF_FRAC_BITS : '0;
         end
         for (int i = 0; i < DELAY_COUNT; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (cmd.op == OP_CAPTURE) begin
         if (req_action == ACT_COEF && 32'(req_coef_index) < COEF_COUNT) begin
            coef_ff[CIW'(req_coef_index)] <= req_coef_value;
         end
      end else if (cmd.op == OP_WB) begin
         delay_ff[dbase]            <= x_cur;
         delay_ff[dbase + DIW'(1)]  <= delay_ff[dbase];
         delay_ff[dbase + DIW'(2)]  <= y_sat;
         delay_ff[dbase + DIW'(3)]  <= delay_ff[dbase + DIW'(2)];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            action_ff <= req_action;
            last_ff   <= req_frame_last;
            in_l_ff   <= req_left_in;
            in_r_ff   <= req_right_in;
            l_ff      <= SIG_W'($signed(req_left_in)) <<< SIG_FRAC_BITS;
            r_ff      <= SIG_W'($signed(req_right_in)) <<< SIG_FRAC_BITS;
         end
         OP_MAC: begin
            prod_ff <= prod_mul;
            neg_ff  <= (k_eff >= 3'd3);
            if (cnt == '0) begin
               acc_ff <= AW'(1) <<< (COEF_FRAC_BITS - 1);
            end else if (neg_ff) begin
               acc_ff <= acc_ff - AW'(prod_ff);
            end else begin
               acc_ff <= acc_ff + AW'(prod_ff);
            end
         end
         OP_WB: begin
            if (ch) begin
               r_ff <= $signed(y_sat);
            end else begin
               l_ff <= $signed(y_sat);
            end
         end
         OP_MS1: begin
            ms_sum_ff <= MW'(sum33) <<< 14;
            ms_dif_ff <= dif33 * $signed({1'b0, w17});
         end
         OP_MS2: begin
            lo_ff <= LW'(ms_l >>> 15);
            ro_ff <= LW'(ms_r >>> 15);
         end
         OP_LSET: begin
            lim_pos_ff <= lpos;
            lim_neg_ff <= lneg;
            num_ff     <= NW'(ld) * NW'(KN);
            den_ff     <= NW'(ld) + NW'(KN);
            q_ff       <= '0;
         end
         OP_LDIV: begin
            if (trial <= num_ff) begin
               num_ff   <= num_ff - trial;
               q_ff[cnt] <= 1'b1;
            end
         end
         OP_LFIN: begin
            if (lim_pos_ff || lim_neg_ff) begin
               if (ch) begin
                  ro_ff <= lres;
               end else begin
                  lo_ff <= lres;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_last_ff <= last_ff;
         rsp_l_ff    <= cmd.bypass ? in_l_ff : to_sample(lo_ff);
         rsp_r_ff    <= cmd.bypass ? in_r_ff : to_sample(ro_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;
   assign rsp_last_out  = rsp_last_ff;

endmodule
`default_nettype wire

[design/stereo_biquad_eq_width_limiter.sv]
// frame path: the active biquad sections per channel on the shared multiplier, then mid/side,
//   then the limiter divider per channel when the limiter is on
// requests are taken one at a time, the next once the previous result is registered; the
//   pace is set by the single shared multiplier and the one-bit-per-cycle limiter divider
// reset: synchronous, clears coefficients to unity b0, zeroes filter history, loads
//   register defaults; no clearing pass is needed
`default_nettype none
module stereo_biquad_eq_width_limiter #(
   parameter int NUM_SECTIONS   = 4,
   parameter int COEF_FRAC_BITS = 28,
   parameter int SIG_FRAC_BITS  = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   sbeq_req_if.sink   req_bus,
   sbeq_rsp_if.source rsp_bus,
   sbeq_csr_if.sink   csr_bus
);
   import sbeq_pkg::*;

   localparam int SECW = $clog2(NUM_SECTIONS + 1);
   localparam int QW   = 10 + SIG_FRAC_BITS;
   localparam int CNTW = $clog2(QW);

   // control registers; the user must write them only while idle, the block does not enforce it
   logic               dsp_enable_ff;
   logic               lowpass_enable_ff;
   logic               limiter_enable_ff;
   logic [WIDTH_W-1:0] side_gain_ff;

   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         dsp_enable_ff     <= 1'b1;
         lowpass_enable_ff <= 1'b0;
         limiter_enable_ff <= 1'b0;
         side_gain_ff      <= WIDTH_W'(16384);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_DSP_ENABLE:     dsp_enable_ff     <= csr_bus.data[0];
            CSR_LOWPASS_ENABLE: lowpass_enable_ff <= csr_bus.data[0];
            CSR_LIMITER_ENABLE: limiter_enable_ff <= csr_bus.data[0];
            CSR_SIDE_GAIN:      side_gain_ff      <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // sequencer to datapath command/status
   dp_cmd_type      cmd;
   dp_status_type   status;
   logic [SECW-1:0] sec;
   logic            ch;
   logic [CNTW-1:0] cnt;

   // one request at a time; the result register lets the next request in while
   // the previous result waits for the sink
   sbeq_ctrl #(
      .NUM_SECTIONS  (NUM_SECTIONS),
      .SIG_FRAC_BITS (SIG_FRAC_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .dsp_enable     (dsp_enable_ff),
      .lowpass_enable (lowpass_enable_ff),
      .limiter_enable (limiter_enable_ff),
      .status         (status),
      .cmd            (cmd),
      .sec            (sec),
      .ch             (ch),
      .cnt            (cnt)
   );

   // coefficient and history storage, shared multiplier, mid/side, limiter divider
   sbeq_dp #(
      .NUM_SECTIONS   (NUM_SECTIONS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .SIG_FRAC_BITS  (SIG_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sec            (sec),
      .ch             (ch),
      .cnt            (cnt),
      .status         (status),
      .side_gain      (side_gain_ff),
      .req_action     (req_bus.action),
      .req_left_in    (req_bus.left_in),
      .req_right_in   (req_bus.right_in),
      .req_frame_last (req_bus.frame_last),
      .req_coef_index (req_bus.coef_index),
      .req_coef_value (req_bus.coef_value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_left_out   (rsp_bus.left_out),
      .rsp_right_out  (rsp_bus.right_out),
      .rsp_last_out   (rsp_bus.last_out)
   );

endmodule
`default_nettype wire

[tb/sbeq_checker.sv]
`default_nettype none
module sbeq_checker (
   input wire logic clock,
   input wire logic reset,
   sbeq_req_if      req_bus,
   sbeq_rsp_if      rsp_bus,
   sbeq_csr_if      csr_bus,
   output int       fail_count,
   output int       pending
);
   import sbeq_pkg::*;

   localparam int NSEC      = 4;
   localparam int CFRAC     = 28;
   localparam int SFRAC     = 8;
   localparam int NCOEF     = NSEC * TAPS;
   localparam int NDELAY    = NSEC * 8;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic        last;
   } eq_frame_type;

   logic signed [31:0] coefs [NCOEF];
   logic signed [31:0] history [NDELAY];
   logic               dsp_on, lowpass_on, limiter_on;
   logic [15:0]        width_q14;
   eq_frame_type       frames_due [$];
   int                 frames_seen;

   assign pending = frames_due.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch frame %0d %s: got %0d want %0d", frames_seen, what, got, want);
      fail_count++;
   endtask

   // one direct-form-i section, exact sum then round half up
   function automatic logic signed [31:0] biquad(input int sec, input int ch,
                                                  input logic signed [31:0] x);
      int                 c, d;
      logic signed [71:0] acc;
      logic signed [71:0] y;
      c = sec * TAPS;
      d = (sec * 2 + ch) * 4;
      acc = longint'(coefs[c]) * longint'(x);
      acc += longint'(coefs[c+1]) * longint'(history[d]);
      acc += longint'(coefs[c+2]) * longint'(history[d+1]);
      acc -= longint'(coefs[c+3]) * longint'(history[d+2]);
      acc -= longint'(coefs[c+4]) * longint'(history[d+3]);
      y = (acc + (72'sd1 <<< (CFRAC - 1))) >>> CFRAC;
      if (y > 72'sh7fffffff) y = 72'sh7fffffff;
      else if (y < -72'sh80000000) y = -72'sh80000000;
      history[d+1] = history[d];
      history[d]   = x;
      history[d+3] = history[d+2];
      history[d+2] = y[31:0];
      return y[31:0];
   endfunction

   function automatic longint knee_limit(input longint v);
      longint t, k, d;
      t = longint'(LIM_THRESH) <<< SFRAC;
      k = longint'(LIM_KNEE) <<< SFRAC;
      if (v > t) begin
         d = v - t;
         return t + (d * k) / (k + d);
      end
      if (v < -t) begin
         d = -t - v;
         return -t - (d * k) / (k + d);
      end
      return v;
   endfunction

   function automatic logic [15:0] to_pcm(input longint v);
      longint s;
      s = (v >= 0) ? (v >>> SFRAC) : -((-v) >>> SFRAC);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[15:0];
   endfunction

   function automatic eq_frame_type equalize(input logic [15:0] l_in, input logic [15:0] r_in,
                                             input logic last);
      eq_frame_type       f;
      logic signed [31:0] l, r;
      longint             w, sum, dif, lo, ro;
      f.last = last;
      if (!dsp_on) begin
         f.left  = l_in;
         f.right = r_in;
         return f;
      end
      l = 32'(signed'(l_in)) <<< SFRAC;
      r = 32'(signed'(r_in)) <<< SFRAC;
      for (int s = 0; s < NSEC; s++) begin
         if (s == 0 && !lowpass_on) continue;
         l = biquad(s, 0, l);
         r = biquad(s, 1, r);
      end
      w   = (width_q14 > WIDTH_MAX) ? WIDTH_MAX : longint'(width_q14);
      sum = (longint'(l) + longint'(r)) * 16384;
      dif = (longint'(l) - longint'(r)) * w;
      lo  = (sum + dif + 16384) >>> 15;
      ro  = (sum - dif + 16384) >>> 15;
      if (limiter_on) begin
         lo = knee_limit(lo);
         ro = knee_limit(ro);
      end
      f.left  = to_pcm(lo);
      f.right = to_pcm(ro);
      return f;
   endfunction

   always @(posedge clock) begin
      eq_frame_type want;
      if (reset) begin
         for (int i = 0; i < NCOEF; i++) coefs[i] = (i % TAPS == 0) ? (32'sd1 <<< CFRAC) : 0;
         for (int i = 0; i < NDELAY; i++) history[i] = 0;
         dsp_on      = 1'b1;
         lowpass_on  = 1'b0;
         limiter_on  = 1'b0;
         width_q14   = 16'd16384;
         frames_due.delete();
         frames_seen = 0;
         fail_count  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frames_due.size() == 0) begin
               report("unexpected", rsp_bus.left_out, 0);
            end else begin
               want = frames_due.pop_front();
               if (rsp_bus.left_out !== want.left)
                  report("left", signed'(rsp_bus.left_out), signed'(want.left));
               if (rsp_bus.right_out !== want.right)
                  report("right", signed'(rsp_bus.right_out), signed'(want.right));
               if (rsp_bus.last_out !== want.last)
                  report("last", rsp_bus.last_out, want.last);
            end
            frames_seen++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_DSP_ENABLE:     dsp_on     = csr_bus.data[0];
               CSR_LOWPASS_ENABLE: lowpass_on = csr_bus.data[0];
               CSR_LIMITER_ENABLE: limiter_on = csr_bus.data[0];
               CSR_SIDE_GAIN:      width_q14  = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.action == ACT_COEF) begin
               if (req_bus.coef_index < NCOEF) coefs[req_bus.coef_index] = req_bus.coef_value;
            end else begin
               frames_due.push_back(equalize(req_bus.left_in, req_bus.right_in,
                                             req_bus.frame_last));
            end
         end
      end
   end
endmodule
`default_nettype wire

[tb/tb_stereo_biquad_eq_width_limiter.sv]
`default_nettype none
module tb_stereo_biquad_eq_width_limiter;
   import sbeq_pkg::*;

   localparam int SETTLE   = 200;   // covers the slowest frame with limiter on
   localparam int WATCHDOG = 5000;  // cycles with no handshake at all
   localparam int HOLD_OFF = 400;   // long receiver stall to back the block up

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   jitter = 1'b1;  // random idling on both sides
   bit   hold_req;       // asks the receiver for its long stall
   bit   hold_done;
   int   quiet_cycles;

   sbeq_req_if req_bus ();
   sbeq_rsp_if rsp_bus ();
   sbeq_csr_if csr_bus ();

   stereo_biquad_eq_width_limiter u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sbeq_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= !jitter || ($urandom_range(99) >= 35);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready) || (pending == 0 && !req_bus.valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   // random gap before a request goes out
   task automatic idle_gap();
      if (jitter && $urandom_range(99) < 35) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_request(input logic act, input logic [15:0] l, input logic [15:0] r,
                               input logic last, input logic [4:0] idx,
                               input logic [31:0] val);
      idle_gap();
      req_bus.action     <= act;
      req_bus.left_in    <= l;
      req_bus.right_in   <= r;
      req_bus.frame_last <= last;
      req_bus.coef_index <= idx;
      req_bus.coef_value <= val;
      req_bus.valid      <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
      send_request(ACT_FRAME, l, r, last, 5'($urandom), $urandom);
   endtask

   task automatic load_coef(input logic [4:0] idx, input logic [31:0] val);
      send_request(ACT_COEF, 16'($urandom), 16'($urandom), 1'($urandom), idx, val);
   endtask

   // block must be idle: all frames out, then room for a trailing coefficient write
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_mode(input logic dsp, input logic lp, input logic lim,
                           input logic [15:0] w);
      drain();
      write_csr(CSR_DSP_ENABLE, {15'($urandom), dsp});
      write_csr(CSR_LOWPASS_ENABLE, {15'($urandom), lp});
      write_csr(CSR_LIMITER_ENABLE, {15'($urandom), lim});
      write_csr(CSR_SIDE_GAIN, w);
   endtask

   // mostly gentle taps so the cascade stays out of saturation
   function automatic logic [31:0] tame_coef(input int slot);
      if (slot == 0) return 32'(1 << 27) + $urandom_range(0, 1 << 28);
      return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
   endfunction

   function automatic logic [15:0] loud_sample();
      case ($urandom_range(3))
         0: return 16'($urandom_range(31000, 32767));
         1: return 16'(-int'($urandom_range(31000, 32768)));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int idx;
      // all inputs known from time zero
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_FRAME;
      req_bus.left_in    = '0;
      req_bus.right_in   = '0;
      req_bus.frame_last = 1'b0;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_DSP_ENABLE;
      csr_bus.data       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unity filters, width one: sample extremes
      send_frame(16'h0000, 16'h0000, 1'b0);
      send_frame(16'h7fff, 16'h7fff, 1'b1);
      send_frame(16'h8000, 16'h8000, 1'b0);
      send_frame(16'h7fff, 16'h8000, 1'b1);
      // writes past the table are dropped
      load_coef(5'd31, 32'h7fffffff);
      load_coef(5'd20, 32'h80000000);
      send_frame(16'h1234, 16'hedcb, 1'b0);
      // coefficient extremes drive the section into saturation
      load_coef(5'd5, 32'h7fffffff);
      send_frame(16'h7fff, 16'h8000, 1'b0);
      load_coef(5'd5, 32'h80000000);
      send_frame(16'h4000, 16'hc000, 1'b1);
      load_coef(5'd5, 32'h10000000);
      load_coef(5'd10, 32'h20000000);
      // limiter with gain two, widest stereo, and width above two
      set_mode(1'b1, 1'b0, 1'b1, 16'd32768);
      send_frame(16'h7fff, 16'h7fff, 1'b0);
      send_frame(16'h8000, 16'h8000, 1'b1);
      send_frame(16'h7d00, 16'h0000, 1'b0);
      set_mode(1'b1, 1'b1, 1'b0, 16'hffff);
      load_coef(5'd1, 32'h08000000);
      load_coef(5'd3, 32'hf8000000);
      send_frame(16'h7fff, 16'h8000, 1'b0);
      send_frame(16'h0100, 16'hff00, 1'b1);
      // mono collapse, then passthrough with frozen history
      set_mode(1'b1, 1'b1, 1'b1, 16'd0);
      send_frame(16'h7fff, 16'h8000, 1'b0);
      set_mode(1'b0, 1'b1, 1'b1, 16'd16384);
      send_frame(16'h8000, 16'h7fff, 1'b1);
      send_frame(16'h0001, 16'hffff, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_mode(1'b1, 1'b0, 1'b0, 16'd16384);
            1: set_mode(1'b1, 1'b1, 1'b1, 16'd32768);
            2: set_mode(1'b1, 1'b1, 1'b0, 16'd0);
            3: set_mode(1'b0, 1'b0, 1'b1, 16'hffff);
            default: set_mode(1'b1, 1'($urandom), 1'($urandom), 16'($urandom_range(0, 40000)));
         endcase
         jitter = (phase != 2);   // one phase runs flat out
         for (int n = 0; n < 85; n++) begin
            if (phase == 1 && n == 20) hold_req = 1'b1;
            case ($urandom_range(19))
               0: load_coef(5'($urandom), $urandom);
               1, 2, 3: begin
                  idx = $urandom_range(0, 19);
                  load_coef(5'(idx), tame_coef(idx % TAPS));
               end
               4, 5, 6: send_frame(loud_sample(), loud_sample(), 1'($urandom));
               default: send_frame(16'($urandom), 16'($urandom), 1'($urandom));
            endcase
         end
      end
      jitter = 1'b1;

      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
